[rtl/bksh_pkg.sv]
// Shared types, codes and helpers of the bounded k-smallest heap.
package bksh_pkg;

   localparam int DATA_W  = 32;
   localparam int CAP_W   = 9;
   localparam int COUNT_W = 9;
   localparam int PADDR_W = 3;

   localparam logic             REG_CAPACITY   = 1'b0;
   localparam logic [CAP_W-1:0] CAPACITY_RESET = 9'd256;

   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef struct packed {
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] value;
   } entry_type;

   // signed greater-than on raw value bits
   function automatic logic val_gt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
      return $signed(a) > $signed(b);
   endfunction

endpackage

[rtl/bksh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module bksh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bksh_csr.sv]
// Configuration register file: capacity register behind an APB-style port.
module bksh_csr
   import bksh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready,
   output logic [CAP_W-1:0]   capacity
);

   logic [CAP_W-1:0] capacity_ff;
   logic [CAP_W-1:0] capacity_in;
   logic             wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[2] == REG_CAPACITY);

   always_comb begin
      capacity_in = capacity_ff;
      if (wr_hit) begin
         capacity_in = pwdata[CAP_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_CAPACITY) begin
         prdata = 32'(capacity_ff);
      end
   end

   assign capacity = capacity_ff;

endmodule

[rtl/bounded_k_smallest_heap.sv]
// Bounded max-heap that keeps the smallest values offered, with a
// request channel (req_), a response channel (rsp_) and an APB-style
// capacity register.
//
// Each request carries an opcode (push, pop, peek, flush) and a key/value
// pair; every request produces exactly one response with found, the key
// and value of the largest entry (pop, peek) and the count afterwards.
// Requests are handled one at a time; req_stall is high while one is in
// work. The heap lives in one RAM of {key, value} words with a registered
// read, so the walk along the tree sets the time:
//   flush, empty pop/peek, first push: straight to the response register
//   peek, full push that is dropped:   one root read, then the response
//   push with room: one parent read per level climbed (at most log2 DEPTH)
//   full push that replaces the root: root read, then a sift-down; pop:
//   root read, last-entry read, sift-down; two child reads per level.
// A finished response sits in the output register; if rsp_stall holds it,
// the next request is still taken and runs up to its own response.
// Reset empties the heap (count 0) and sets capacity to 256; no RAM
// clearing is done.
module bounded_k_smallest_heap
   import bksh_pkg::*;
#(
   parameter int DEPTH = 256
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic signed [31:0]         req_in_key,
   input  logic signed [31:0]         req_in_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_found,
   output logic signed [31:0]         rsp_out_key,
   output logic signed [31:0]         rsp_out_value,
   output logic [8:0]                 rsp_count,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [2:0]                 paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IW   = AW + 2;
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_LAST,
      ST_UP,
      ST_DN_L,
      ST_DN_R,
      ST_WX,
      ST_FIN
   } state_type;

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       hole_ff, hole_in;
   entry_type           x_ff, x_in;
   entry_type           lch_ff, lch_in;
   logic                found_ff, found_in;
   entry_type           res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_found_ff, rsp_found_in;
   entry_type           rsp_ent_ff, rsp_ent_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic [CAP_W-1:0]    capacity;
   logic [CMPW-1:0]     cap_ext, eff_cap, count_ext;
   logic                has_room;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_wa, ram_ra;
   entry_type           ram_wd;
   logic [$bits(entry_type)-1:0] ram_rd_raw;
   entry_type           rd;

   logic [IW-1:0]       n_w, left_w, right_w, nl_left_w, nl_right_w;
   logic [AW-1:0]       parent, parent_up;
   logic                take_l, take_r;
   logic [DATA_W-1:0]   big_v;

   bksh_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready),
      .capacity (capacity)
   );

   bksh_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_en   (ram_re),
      .rd_addr (ram_ra),
      .rd_data (ram_rd_raw)
   );

   assign rd = entry_type'(ram_rd_raw);

   // effective capacity: zero acts as one, anything above DEPTH saturates
   always_comb begin
      cap_ext   = CMPW'(capacity);
      count_ext = CMPW'(count_ff);
      eff_cap   = cap_ext;
      if (cap_ext == '0) begin
         eff_cap = CMPW'(1);
      end else if (cap_ext > CMPW'(DEPTH)) begin
         eff_cap = CMPW'(DEPTH);
      end
      has_room = count_ext < eff_cap;
   end

   // tree index arithmetic around the current hole
   always_comb begin
      n_w        = IW'(count_ff);
      left_w     = {1'b0, hole_ff, 1'b1};
      right_w    = left_w + IW'(1);
      nl_left_w  = {1'b0, left_w[AW-1:0], 1'b1};
      nl_right_w = {1'b0, right_w[AW-1:0], 1'b1};
      parent     = AW'((hole_ff - AW'(1)) >> 1);
      parent_up  = AW'((parent - AW'(1)) >> 1);
      take_l     = val_gt(lch_ff.value, x_ff.value);
      big_v      = take_l ? lch_ff.value : x_ff.value;
      take_r     = val_gt(rd.value, big_v);
   end

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      count_in     = count_ff;
      hole_in      = hole_ff;
      x_in         = x_ff;
      lch_in       = lch_ff;
      found_in     = found_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_ent_in   = rsp_ent_ff;
      rsp_count_in = rsp_count_ff;
      ram_we       = 1'b0;
      ram_wa       = hole_ff;
      ram_wd       = x_ff;
      ram_re       = 1'b0;
      ram_ra       = '0;

      // drop the response once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = op_type'(req_opcode);
               x_in     = '{key: req_in_key, value: req_in_value};
               found_in = 1'b0;
               res_in   = '0;
               case (op_type'(req_opcode))
                  OP_PUSH: begin
                     if (has_room) begin
                        if (count_ff == '0) begin
                           ram_we   = 1'b1;
                           ram_wa   = '0;
                           ram_wd   = '{key: req_in_key, value: req_in_value};
                           count_in = CW'(1);
                           state_in = ST_FIN;
                        end else begin
                           hole_in  = count_ff[AW-1:0];
                           count_in = count_ff + CW'(1);
                           ram_re   = 1'b1;
                           ram_ra   = AW'((count_ff - CW'(1)) >> 1);
                           state_in = ST_UP;
                        end
                     end else begin
                        ram_re   = 1'b1;
                        state_in = ST_ROOT;
                     end
                  end
                  OP_POP, OP_PEEK: begin
                     if (count_ff == '0) begin
                        state_in = ST_FIN;
                     end else begin
                        ram_re   = 1'b1;
                        state_in = ST_ROOT;
                     end
                  end
                  OP_FLUSH: begin
                     count_in = '0;
                     state_in = ST_FIN;
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end

         ST_ROOT: begin
            case (op_ff)
               OP_PUSH: begin
                  if (val_gt(rd.value, x_ff.value)) begin
                     // replace the root: sift the new pair down from the top
                     hole_in = '0;
                     if (count_ff > CW'(1)) begin
                        ram_re   = 1'b1;
                        ram_ra   = AW'(1);
                        state_in = ST_DN_L;
                     end else begin
                        ram_we   = 1'b1;
                        ram_wa   = '0;
                        state_in = ST_FIN;
                     end
                  end else begin
                     state_in = ST_FIN;
                  end
               end
               OP_PEEK: begin
                  found_in = 1'b1;
                  res_in   = rd;
                  state_in = ST_FIN;
               end
               OP_POP: begin
                  found_in = 1'b1;
                  res_in   = rd;
                  count_in = count_ff - CW'(1);
                  if (count_ff > CW'(1)) begin
                     ram_re   = 1'b1;
                     ram_ra   = AW'(count_ff - CW'(1));
                     state_in = ST_LAST;
                  end else begin
                     state_in = ST_FIN;
                  end
               end
               default: begin
                  state_in = ST_FIN;
               end
            endcase
         end

         ST_LAST: begin
            // last entry moves to the root and sifts down
            x_in    = rd;
            hole_in = '0;
            if (count_ff > CW'(1)) begin
               ram_re   = 1'b1;
               ram_ra   = AW'(1);
               state_in = ST_DN_L;
            end else begin
               ram_we   = 1'b1;
               ram_wa   = '0;
               ram_wd   = rd;
               state_in = ST_FIN;
            end
         end

         ST_UP: begin
            if (val_gt(x_ff.value, rd.value)) begin
               // pull the parent down into the hole and climb
               ram_we  = 1'b1;
               ram_wd  = rd;
               hole_in = parent;
               if (parent != '0) begin
                  ram_re   = 1'b1;
                  ram_ra   = parent_up;
               end else begin
                  state_in = ST_WX;
               end
            end else begin
               ram_we   = 1'b1;
               state_in = ST_FIN;
            end
         end

         ST_DN_L: begin
            lch_in = rd;
            if (right_w < n_w) begin
               ram_re   = 1'b1;
               ram_ra   = right_w[AW-1:0];
               state_in = ST_DN_R;
            end else if (val_gt(rd.value, x_ff.value)) begin
               ram_we  = 1'b1;
               ram_wd  = rd;
               hole_in = left_w[AW-1:0];
               if (nl_left_w < n_w) begin
                  ram_re   = 1'b1;
                  ram_ra   = nl_left_w[AW-1:0];
                  state_in = ST_DN_L;
               end else begin
                  state_in = ST_WX;
               end
            end else begin
               ram_we   = 1'b1;
               state_in = ST_FIN;
            end
         end

         ST_DN_R: begin
            if (take_r) begin
               ram_we  = 1'b1;
               ram_wd  = rd;
               hole_in = right_w[AW-1:0];
               if (nl_right_w < n_w) begin
                  ram_re   = 1'b1;
                  ram_ra   = nl_right_w[AW-1:0];
                  state_in = ST_DN_L;
               end else begin
                  state_in = ST_WX;
               end
            end else if (take_l) begin
               ram_we  = 1'b1;
               ram_wd  = lch_ff;
               hole_in = left_w[AW-1:0];
               if (nl_left_w < n_w) begin
                  ram_re   = 1'b1;
                  ram_ra   = nl_left_w[AW-1:0];
                  state_in = ST_DN_L;
               end else begin
                  state_in = ST_WX;
               end
            end else begin
               ram_we   = 1'b1;
               state_in = ST_FIN;
            end
         end

         ST_WX: begin
            ram_we   = 1'b1;
            state_in = ST_FIN;
         end

         ST_FIN: begin
            // hold until the response register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_ent_in   = res_ff;
               rsp_count_in = COUNT_W'(count_ff);
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff        <= op_in;
      hole_ff      <= hole_in;
      x_ff         <= x_in;
      lch_ff       <= lch_in;
      found_ff     <= found_in;
      res_ff       <= res_in;
      rsp_found_ff <= rsp_found_in;
      rsp_ent_ff   <= rsp_ent_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_out_key   = rsp_ent_ff.key;
   assign rsp_out_value = rsp_ent_ff.value;
   assign rsp_count     = rsp_count_ff;

endmodule
